// File: design/wrt_pkg.sv
// ----------------------------------------------------------------------------
// wrt_pkg: shared types and codes of the wake retry table
// Request and response words, opcodes, result kinds, register indexes.
// ----------------------------------------------------------------------------
package wrt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIM   = 8'd1;

	localparam logic [15:0] ACK_TIMEOUT_RST = 16'd5000;
	localparam logic [7:0]  RETRY_LIM_RST   = 8'd3;

	localparam logic [2:0] OP_SEND  = 3'd0;
	localparam logic [2:0] OP_ACK   = 3'd1;
	localparam logic [2:0] OP_DONE  = 3'd2;
	localparam logic [2:0] OP_CLOSE = 3'd3;
	localparam logic [2:0] OP_TICK  = 3'd4;

	localparam logic [3:0] KIND_STORED    = 4'd0;
	localparam logic [3:0] KIND_REPLACED  = 4'd1;
	localparam logic [3:0] KIND_FULL      = 4'd2;
	localparam logic [3:0] KIND_REMOVED   = 4'd3;
	localparam logic [3:0] KIND_NOT_FOUND = 4'd4;
	localparam logic [3:0] KIND_RESEND    = 4'd5;
	localparam logic [3:0] KIND_FAILED    = 4'd6;
	localparam logic [3:0] KIND_SKIPPED   = 4'd7;
	localparam logic [3:0] KIND_DONE      = 4'd8;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] msg_tag;
		logic [15:0] device;
		logic [31:0] now_ms;
	} req_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [3:0]  slot;
		logic [31:0] tag_out;
		logic [15:0] device_out;
		logic [7:0]  retries;
		logic        last;
	} rsp_t;

endpackage

// File: design/wake_retry_table.sv
// ----------------------------------------------------------------------------
// wake_retry_table: pending wake message table with resend timer
// Holds messages awaiting acknowledgment; a tick resends, skips or fails
// expired entries with a wrap-safe deadline check.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel (req_valid/req_ready/req) takes one command word: send, ack,
//    done, session closed or tick. rsp channel returns result words; the
//    final word of a command has last set.
//  - cfg channel writes the ack timeout in ms (index 0) and the retry limit
//    (index 1). It is always ready; write it only while the table is idle.
//  - Every command walks all TABLE_DEPTH slots, one slot per cycle unless a
//    tick holds the walk (below), through a single slot read port and one
//    deadline compare, then emits the closing word and goes back to idle to
//    take the next word. req_ready is low until the table is back in idle.
//  - A tick reports expired entries from inside the walk; if rsp is stalled
//    while an expired slot comes up, the walk holds on that slot.
//  - One response word is buffered, so the closing word can wait in the
//    output register while the next command is taken.
//  - Reset empties the table and loads a 5000 ms timeout and a retry limit
//    of 3.
// ----------------------------------------------------------------------------
module wake_retry_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  wrt_pkg::req_t                   req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output wrt_pkg::rsp_t                   rsp,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wrt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wrt_pkg::CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	localparam int DEPTH = wrt_pkg::TABLE_DEPTH;
	localparam int SW    = wrt_pkg::SLOT_W;
	localparam logic [SW-1:0] IDX_LAST = SW'(DEPTH - 1);

	state_t            state_q;
	wrt_pkg::req_t     req_q;
	logic [31:0]       renew_q;
	logic [SW-1:0]     idx_q;
	logic              match_q;
	logic [SW-1:0]     match_idx_q;
	logic [15:0]       match_dev_q;
	logic [7:0]        match_ret_q;
	logic              free_q;
	logic [SW-1:0]     free_idx_q;
	logic [DEPTH-1:0]  valid_q;
	logic [15:0]       ack_timeout_q;
	logic [7:0]        retry_lim_q;
	logic              rsp_valid_q;
	wrt_pkg::rsp_t     rsp_q;

	logic [31:0] tag_mem      [DEPTH];
	logic [15:0] dev_mem      [DEPTH];
	logic [7:0]  retry_mem    [DEPTH];
	logic [31:0] deadline_mem [DEPTH];
	logic        deliv_mem    [DEPTH];

	logic [31:0] rd_tag, rd_deadline, age;
	logic [15:0] rd_dev;
	logic [7:0]  rd_retry, retry_inc;
	logic        rd_deliv, rd_valid;
	logic        expired, hit, can_emit, tick_event, scan_go, is_fail;
	logic        send_wr, ack_rm, tick_renew, close_clr, rsp_load;
	logic [SW-1:0] wr_idx;
	wrt_pkg::rsp_t fin_rsp;

	// single read port at the walk index
	assign rd_tag      = tag_mem[idx_q];
	assign rd_dev      = dev_mem[idx_q];
	assign rd_retry    = retry_mem[idx_q];
	assign rd_deadline = deadline_mem[idx_q];
	assign rd_deliv    = deliv_mem[idx_q];
	assign rd_valid    = valid_q[idx_q];

	// wrap-safe: expired when now - deadline is non-negative as signed
	assign age        = req_q.now_ms - rd_deadline;
	assign expired    = ~age[31];
	assign hit        = rd_valid && (rd_tag == req_q.msg_tag);
	assign retry_inc  = rd_retry + 8'd1;
	assign is_fail    = (rd_retry >= retry_lim_q);
	assign can_emit   = !rsp_valid_q || rsp_ready;
	assign tick_event = (state_q == ST_SCAN) && (req_q.opcode == wrt_pkg::OP_TICK)
		&& rd_valid && expired;
	assign scan_go    = (state_q == ST_SCAN) && (!tick_event || can_emit);

	assign tick_renew = scan_go && tick_event && !is_fail && rd_deliv;
	assign close_clr  = scan_go && (req_q.opcode == wrt_pkg::OP_CLOSE) && rd_valid
		&& (rd_dev == req_q.device);
	assign send_wr    = (state_q == ST_FINISH) && can_emit
		&& (req_q.opcode == wrt_pkg::OP_SEND) && (match_q || free_q);
	assign ack_rm     = (state_q == ST_FINISH) && can_emit && match_q
		&& ((req_q.opcode == wrt_pkg::OP_ACK) || (req_q.opcode == wrt_pkg::OP_DONE));
	assign wr_idx     = match_q ? match_idx_q : free_idx_q;
	assign rsp_load   = (scan_go && tick_event) || ((state_q == ST_FINISH) && can_emit);

	assign req_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// closing word of the command
	always_comb begin
		fin_rsp      = '0;
		fin_rsp.kind = wrt_pkg::KIND_DONE;
		fin_rsp.last = 1'b1;
		unique case (req_q.opcode) inside
			wrt_pkg::OP_SEND: begin
				fin_rsp.tag_out    = req_q.msg_tag;
				fin_rsp.device_out = req_q.device;
				if (match_q) begin
					fin_rsp.kind = wrt_pkg::KIND_REPLACED;
					fin_rsp.slot = 4'(match_idx_q);
				end else if (free_q) begin
					fin_rsp.kind = wrt_pkg::KIND_STORED;
					fin_rsp.slot = 4'(free_idx_q);
				end else begin
					fin_rsp.kind = wrt_pkg::KIND_FULL;
				end
			end
			wrt_pkg::OP_ACK, wrt_pkg::OP_DONE: begin
				fin_rsp.tag_out = req_q.msg_tag;
				if (match_q) begin
					fin_rsp.kind       = wrt_pkg::KIND_REMOVED;
					fin_rsp.slot       = 4'(match_idx_q);
					fin_rsp.device_out = match_dev_q;
					fin_rsp.retries    = match_ret_q;
				end else begin
					fin_rsp.kind = wrt_pkg::KIND_NOT_FOUND;
				end
			end
			wrt_pkg::OP_CLOSE: begin
				fin_rsp.device_out = req_q.device;
			end
			default: ;
		endcase
	end

	// entry payload, written at the walk index or at the chosen send slot
	always_ff @(posedge clk) begin
		if (send_wr) begin
			tag_mem[wr_idx]      <= req_q.msg_tag;
			dev_mem[wr_idx]      <= req_q.device;
			retry_mem[wr_idx]    <= 8'd0;
			deadline_mem[wr_idx] <= renew_q;
			deliv_mem[wr_idx]    <= 1'b1;
		end
		if (tick_renew) begin
			retry_mem[idx_q]    <= retry_inc;
			deadline_mem[idx_q] <= renew_q;
		end
		if (close_clr) begin
			deliv_mem[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			rsp_valid_q   <= 1'b0;
			ack_timeout_q <= wrt_pkg::ACK_TIMEOUT_RST;
			retry_lim_q   <= wrt_pkg::RETRY_LIM_RST;
			idx_q         <= '0;
			match_q       <= 1'b0;
			free_q        <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					wrt_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data;
					wrt_pkg::REG_RETRY_LIM:   retry_lim_q   <= cfg_data[7:0];
					default: ;
				endcase
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						renew_q <= req.now_ms + {16'd0, ack_timeout_q};
						idx_q   <= '0;
						match_q <= 1'b0;
						free_q  <= 1'b0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_go) begin
						if (hit && !match_q) begin
							match_q     <= 1'b1;
							match_idx_q <= idx_q;
							match_dev_q <= rd_dev;
							match_ret_q <= rd_retry;
						end
						if (!rd_valid && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_q;
						end
						if (tick_event) begin
							rsp_q.slot         <= 4'(idx_q);
							rsp_q.tag_out      <= rd_tag;
							rsp_q.device_out   <= rd_dev;
							rsp_q.last         <= 1'b0;
							if (is_fail) begin
								rsp_q.kind    <= wrt_pkg::KIND_FAILED;
								rsp_q.retries <= rd_retry;
								valid_q[idx_q] <= 1'b0;
							end else if (!rd_deliv) begin
								rsp_q.kind    <= wrt_pkg::KIND_SKIPPED;
								rsp_q.retries <= rd_retry;
							end else begin
								rsp_q.kind    <= wrt_pkg::KIND_RESEND;
								rsp_q.retries <= retry_inc;
							end
						end
						idx_q <= idx_q + SW'(1);
						if (idx_q == IDX_LAST) begin
							state_q <= ST_FINISH;
						end
					end
				end
				ST_FINISH: begin
					if (can_emit) begin
						rsp_q <= fin_rsp;
						if (send_wr) begin
							valid_q[wr_idx] <= 1'b1;
						end
						if (ack_rm) begin
							valid_q[match_idx_q] <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_start_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_SCAN && idx_q == '0))
		else $error("walk did not start at slot zero");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || rsp_ready))
		else $error("pending response word overwritten");

	a_fail_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_go && tick_event && is_fail) |=> !valid_q[$past(idx_q)])
		else $error("failed entry still valid");

	a_send_holds: assert property (@(posedge clk) disable iff (!arst_n)
		send_wr |=> valid_q[$past(wr_idx)])
		else $error("sent entry not marked valid");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FINISH) && can_emit) |=> (rsp_valid_q && rsp_q.last
			&& state_q == ST_IDLE))
		else $error("closing word missing");
`endif

endmodule
